// ===== src/frame_slot_pool_manager_defines.svh =====
// Assertion macros shared by the frame slot pool manager RTL.
`ifndef FRAME_SLOT_POOL_MANAGER_DEFINES_SVH
`define FRAME_SLOT_POOL_MANAGER_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define FSPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: invariant violated");

// Implication checked at every clock edge outside reset.
`define FSPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication violated");

`endif

// ===== src/fspm_pkg.sv =====
// Types and constants of the frame slot pool manager.
`timescale 1ns / 1ps

package fspm_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned SLOT_CNT_W = $clog2(SLOTS + 1);

  localparam logic [7:0]            SLOT_ID_LIMIT = 8'(SLOTS);
  localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT    = SLOT_CNT_W'(SLOTS);
  localparam logic [4:0]            THRESH_RESET  = 5'd1;

  typedef enum logic [2:0] {
    OP_ACQ_WRITE = 3'd0,
    OP_ACQ_READ  = 3'd1,
    OP_READ_DONE = 3'd2,
    OP_WRITE_OK  = 3'd3,
    OP_WRITE_BAD = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NOT_OWNED = 2'd2,
    ST_BAD_PHASE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_WRITE = 2'd1,
    PH_PREP  = 2'd2,
    PH_READ  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] slot_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] granted_slot;
    logic       overwrote_prepared;
    logic [4:0] prepared_count;
  } rsp_t;

endpackage

// ===== src/frame_slot_pool_manager.sv =====
// Frame slot pool manager: slot grant and return bookkeeping.
//
// Requests arrive on the in channel (in_valid_i / in_stall_o, payload
// in_data_i) and each produces exactly one response on the out channel
// (out_valid_o / out_stall_i, payload out_data_o). A transfer happens on a
// rising edge with valid high and stall low.
// A request is captured in the input register, the stack/FIFO/phase update
// runs combinationally from there and lands in the response register. One
// request per cycle is sustained while the receiver does not stall; the
// rate is set by the single-pass update of the 16-entry slot register file.
// When the receiver stalls, the response register holds and the input
// register keeps one more request; in_stall_o rises once both are full.
// The overwrite threshold is written via cfg_valid_i / cfg_ready_o /
// cfg_data_i, by the user only while the block is idle; this is not enforced.
// cfg_ready_o is always high. Reset puts every slot in the empty phase,
// loads the empty stack with ids 0..15 (top is 15), clears the prepared
// FIFO and sets the threshold to 1. No clearing pass is needed.
`timescale 1ns / 1ps
`include "frame_slot_pool_manager_defines.svh"

module frame_slot_pool_manager
  import fspm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  // input register
  logic in_valid_q, in_valid_d;
  req_t in_q, in_d;

  // response register
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  logic [4:0] thresh_q, thresh_d;

  // slot bookkeeping
  phase_e                slot_phase_q  [SLOTS];
  phase_e                slot_phase_d  [SLOTS];
  logic [SLOT_W-1:0]     empty_stack_q [SLOTS];
  logic [SLOT_W-1:0]     empty_stack_d [SLOTS];
  logic [SLOT_CNT_W-1:0] empty_depth_q, empty_depth_d;
  logic [SLOT_W-1:0]     prep_fifo_q   [SLOTS];
  logic [SLOT_W-1:0]     prep_fifo_d   [SLOTS];
  logic [SLOT_W-1:0]     fifo_head_q, fifo_head_d;
  logic [SLOT_W-1:0]     fifo_tail_q, fifo_tail_d;
  logic [SLOT_CNT_W-1:0] fifo_count_q, fifo_count_d;

  logic in_xfer;
  logic rsp_free;
  logic fire;

  assign rsp_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && rsp_free;
  assign in_stall_o = in_valid_q && !rsp_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    in_valid_d = in_xfer || (in_valid_q && !fire);
    in_d       = in_xfer ? in_data_i : in_q;
    thresh_d   = cfg_valid_i ? cfg_data_i : thresh_q;
  end

  // Single-pass update of the pool for the registered request.
  always_comb begin
    logic [SLOT_CNT_W-1:0] depth_m1;
    logic [SLOT_W-1:0]     id;
    logic [SLOT_W-1:0]     sid;
    logic                  sid_ok;
    phase_e                need;
    status_e               status;
    logic [SLOT_W-1:0]     granted;
    logic                  over;

    slot_phase_d  = slot_phase_q;
    empty_stack_d = empty_stack_q;
    empty_depth_d = empty_depth_q;
    prep_fifo_d   = prep_fifo_q;
    fifo_head_d   = fifo_head_q;
    fifo_tail_d   = fifo_tail_q;
    fifo_count_d  = fifo_count_q;

    depth_m1 = empty_depth_q - SLOT_CNT_W'(1);
    id       = '0;
    sid      = in_q.slot_id[SLOT_W-1:0];
    sid_ok   = in_q.slot_id < SLOT_ID_LIMIT;
    need     = (opcode_e'(in_q.opcode) == OP_READ_DONE) ? PH_READ : PH_WRITE;
    status   = ST_OK;
    granted  = '0;
    over     = 1'b0;

    unique case (opcode_e'(in_q.opcode))
      OP_ACQ_WRITE: begin
        if (empty_depth_q != '0) begin
          id                = empty_stack_q[depth_m1[SLOT_W-1:0]];
          empty_depth_d     = depth_m1;
          slot_phase_d[id]  = PH_WRITE;
          granted           = id;
        end else if (fifo_count_q != '0 && 5'(fifo_count_q) >= thresh_q) begin
          // no empty slot: reclaim the oldest unread frame
          id                = prep_fifo_q[fifo_head_q];
          fifo_head_d       = fifo_head_q + SLOT_W'(1);
          fifo_count_d      = fifo_count_q - SLOT_CNT_W'(1);
          slot_phase_d[id]  = PH_WRITE;
          granted           = id;
          over              = 1'b1;
        end else begin
          status = ST_NO_SLOT;
        end
      end
      OP_ACQ_READ: begin
        if (fifo_count_q != '0) begin
          id                = prep_fifo_q[fifo_head_q];
          fifo_head_d       = fifo_head_q + SLOT_W'(1);
          fifo_count_d      = fifo_count_q - SLOT_CNT_W'(1);
          slot_phase_d[id]  = PH_READ;
          granted           = id;
        end else begin
          status = ST_NO_SLOT;
        end
      end
      OP_READ_DONE, OP_WRITE_OK, OP_WRITE_BAD: begin
        if (!sid_ok) begin
          status = ST_NOT_OWNED;
        end else if (slot_phase_q[sid] != need) begin
          status = ST_BAD_PHASE;
        end else if (opcode_e'(in_q.opcode) == OP_WRITE_OK) begin
          slot_phase_d[sid] = PH_PREP;
          if (fifo_count_q < SLOT_COUNT) begin
            prep_fifo_d[fifo_tail_q] = sid;
            fifo_tail_d              = fifo_tail_q + SLOT_W'(1);
            fifo_count_d             = fifo_count_q + SLOT_CNT_W'(1);
          end
        end else begin
          slot_phase_d[sid] = PH_EMPTY;
          if (empty_depth_q < SLOT_COUNT) begin
            empty_stack_d[empty_depth_q[SLOT_W-1:0]] = sid;
            empty_depth_d                            = empty_depth_q + SLOT_CNT_W'(1);
          end
        end
      end
      default: begin
        // unused opcodes leave the pool untouched
        status = ST_OK;
      end
    endcase

    out_d.status             = status;
    out_d.granted_slot       = 4'(granted);
    out_d.overwrote_prepared = over;
    out_d.prepared_count     = 5'(fifo_count_d);
    out_valid_d              = fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      thresh_q      <= THRESH_RESET;
      empty_depth_q <= SLOT_COUNT;
      fifo_head_q   <= '0;
      fifo_tail_q   <= '0;
      fifo_count_q  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_phase_q[i]  <= PH_EMPTY;
        empty_stack_q[i] <= SLOT_W'(i);
      end
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      thresh_q    <= thresh_d;
      if (fire) begin
        empty_depth_q <= empty_depth_d;
        fifo_head_q   <= fifo_head_d;
        fifo_tail_q   <= fifo_tail_d;
        fifo_count_q  <= fifo_count_d;
        slot_phase_q  <= slot_phase_d;
        empty_stack_q <= empty_stack_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    if (fire) begin
      out_q       <= out_d;
      prep_fifo_q <= prep_fifo_d;
    end
  end

  // every slot sits in at most one of the two stores
  `FSPM_ASSERT(a_pool_conserved, clk_i, rst_ni,
    ({1'b0, empty_depth_q} + {1'b0, fifo_count_q}) <= {1'b0, SLOT_COUNT})
  // input side only stalls when both registers are occupied
  `FSPM_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni,
    in_stall_o, in_valid_q && out_valid_q && out_stall_i)
  // an overwrite is only granted with an empty stack and an ok status
  `FSPM_ASSERT_IMPL(a_overwrite_ok, clk_i, rst_ni,
    fire && out_d.overwrote_prepared,
    empty_depth_q == '0 && out_d.status == ST_OK)
  // a granted read always hands out a slot that was prepared
  `FSPM_ASSERT_IMPL(a_read_grant_prep, clk_i, rst_ni,
    fire && opcode_e'(in_q.opcode) == OP_ACQ_READ && out_d.status == ST_OK,
    slot_phase_q[prep_fifo_q[fifo_head_q]] == PH_PREP)

endmodule

// ===== tb/frame_slot_pool_manager_test.sv =====
// Self-checking testbench for the frame slot pool manager: predictor, driver and monitor.
`timescale 1ns / 1ps

module frame_slot_pool_manager_test;
  import fspm_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 238;
  localparam int unsigned MAX_REPORTS = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  req_t       in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rsp_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  frame_slot_pool_manager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Pool shadow state
  phase_e     pool_phase[SLOTS];
  logic [3:0] free_stack[SLOTS];
  int         free_depth;
  logic [3:0] prep_fifo[SLOTS];
  int         prep_head;
  int         prep_tail;
  int         prep_count;
  logic [4:0] overwrite_thresh;

  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];

  int          idle_pct = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned rsp_cnt = 0;
  int unsigned overwrite_cnt = 0;
  int unsigned no_slot_cnt = 0;
  int unsigned cfg_cnt = 0;
  rsp_t        want_rsp;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("Timed out with %0d responses still outstanding", expected_rsp_q.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(99) < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [3:0] pop_prepared();
    logic [3:0] id;
    id = prep_fifo[prep_head];
    prep_head = (prep_head + 1) % SLOTS;
    prep_count--;
    return id;
  endfunction

  function automatic rsp_t predict_response(input req_t req);
    rsp_t       res;
    logic [3:0] id;
    phase_e     need;
    res = '0;
    case (req.opcode)
      OP_ACQ_WRITE: begin
        if (free_depth > 0) begin
          free_depth--;
          id = free_stack[free_depth];
          pool_phase[id] = PH_WRITE;
          res.granted_slot = id;
        end else if (prep_count > 0 && prep_count >= overwrite_thresh) begin
          id = pop_prepared();
          pool_phase[id] = PH_WRITE;
          res.granted_slot = id;
          res.overwrote_prepared = 1'b1;
          overwrite_cnt++;
        end else begin
          res.status = ST_NO_SLOT;
          no_slot_cnt++;
        end
      end
      OP_ACQ_READ: begin
        if (prep_count > 0) begin
          id = pop_prepared();
          pool_phase[id] = PH_READ;
          res.granted_slot = id;
        end else begin
          res.status = ST_NO_SLOT;
          no_slot_cnt++;
        end
      end
      OP_READ_DONE, OP_WRITE_OK, OP_WRITE_BAD: begin
        need = (req.opcode == OP_READ_DONE) ? PH_READ : PH_WRITE;
        id = req.slot_id[3:0];
        if (req.slot_id >= SLOTS) begin
          res.status = ST_NOT_OWNED;
        end else if (pool_phase[id] != need) begin
          res.status = ST_BAD_PHASE;
        end else if (req.opcode == OP_WRITE_OK) begin
          pool_phase[id] = PH_PREP;
          if (prep_count < SLOTS) begin
            prep_fifo[prep_tail] = id;
            prep_tail = (prep_tail + 1) % SLOTS;
            prep_count++;
          end
        end else begin
          pool_phase[id] = PH_EMPTY;
          if (free_depth < SLOTS) begin
            free_stack[free_depth] = id;
            free_depth++;
          end
        end
      end
      default: ;
    endcase
    res.prepared_count = 5'(prep_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t ERROR response %0d: %s got %0d, expected %0d",
               $time, rsp_cnt, what, got, want);
  endtask

  function automatic void queue_req(input logic [2:0] op, input logic [7:0] id);
    req_t req;
    req.opcode = op;
    req.slot_id = id;
    pending_req_q = {pending_req_q, req};
  endfunction

  // Blocks until every queued request has been sent and answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || in_valid_i || expected_rsp_q.size() != 0);
  endtask

  task automatic write_threshold(input logic [4:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    overwrite_thresh = value;
    cfg_cnt++;
  endtask

  // Request driver: prediction is taken at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_rsp_q = {expected_rsp_q, predict_response(in_data_i)};
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          in_data_i <= pending_req_q[0];
          pending_req_q.delete(0);
          in_valid_i <= 1'b1;
          if (idle_pct > 0 && $urandom_range(99) < idle_pct) send_gap = gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        rsp_cnt++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with nothing expected, status", out_data_o.status, 0);
        end else begin
          want_rsp = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          if (out_data_o.status !== want_rsp.status)
            report_mismatch("status", out_data_o.status, want_rsp.status);
          if (out_data_o.granted_slot !== want_rsp.granted_slot)
            report_mismatch("granted_slot", out_data_o.granted_slot, want_rsp.granted_slot);
          if (out_data_o.overwrote_prepared !== want_rsp.overwrote_prepared)
            report_mismatch("overwrote_prepared", out_data_o.overwrote_prepared,
                            want_rsp.overwrote_prepared);
          if (out_data_o.prepared_count !== want_rsp.prepared_count)
            report_mismatch("prepared_count", out_data_o.prepared_count,
                            want_rsp.prepared_count);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        stall_left = gap_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int         read_tbl[NUM_PHASES];
    int         ret_tbl[NUM_PHASES];
    int         idle_tbl[NUM_PHASES];
    logic [4:0] thresh_tbl[NUM_PHASES];
    int         held_q[$];
    int         roll;
    int         pick;
    req_t       req;

    read_tbl   = '{5, 25, 3, 30, 15, 35, 10, 20};
    ret_tbl    = '{45, 40, 20, 45, 35, 40, 15, 45};
    idle_tbl   = '{0, 25, 10, 40, 0, 15, 30, 5};
    thresh_tbl = '{THRESH_RESET, 5'd0, 5'd16, 5'd4, 5'd9, 5'd1, 5'd15, 5'd2};

    for (int i = 0; i < SLOTS; i++) begin
      pool_phase[i] = PH_EMPTY;
      free_stack[i] = 4'(i);
      prep_fifo[i] = '0;
    end
    free_depth = SLOTS;
    prep_head = 0;
    prep_tail = 0;
    prep_count = 0;
    overwrite_thresh = THRESH_RESET;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reads with no prepared slot, bad ids, reserved opcodes, one full slot cycle
    queue_req(OP_ACQ_READ, 8'h00);
    queue_req(OP_READ_DONE, 8'hFF);
    queue_req(OP_WRITE_OK, 8'(SLOTS));
    queue_req(OP_WRITE_BAD, 8'h00);
    queue_req(OP_RSVD_A, 8'h00);
    queue_req(OP_RSVD_B, 8'hFF);
    queue_req(OP_RSVD_C, 8'h5A);
    queue_req(OP_ACQ_WRITE, 8'hA5);
    queue_req(OP_READ_DONE, 8'd15);
    queue_req(OP_WRITE_OK, 8'd15);
    queue_req(OP_WRITE_OK, 8'd15);
    queue_req(OP_ACQ_WRITE, 8'h00);
    queue_req(OP_WRITE_BAD, 8'd14);
    queue_req(OP_ACQ_READ, 8'hFF);
    queue_req(OP_READ_DONE, 8'd15);
    queue_req(OP_ACQ_READ, 8'h00);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // phase 0 runs on the reset threshold
      if (ph != 0) write_threshold(thresh_tbl[ph]);
      idle_pct = idle_tbl[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while (pending_req_q.size() != 0) @(negedge clk_i);
        held_q.delete();
        for (int i = 0; i < SLOTS; i++)
          if (pool_phase[i] == PH_WRITE || pool_phase[i] == PH_READ) held_q = {held_q, i};
        req.opcode = OP_ACQ_WRITE;
        req.slot_id = 8'($urandom());
        roll = $urandom_range(99);
        if ($urandom_range(99) < 8) begin
          // noise: any opcode, any id
          req.opcode = 3'($urandom());
          if ($urandom_range(1) == 0) req.slot_id = 8'($urandom_range(SLOTS - 1));
        end else if (roll < read_tbl[ph]) begin
          req.opcode = OP_ACQ_READ;
        end else if (roll < read_tbl[ph] + ret_tbl[ph] && held_q.size() > 0) begin
          pick = held_q[$urandom_range(held_q.size() - 1)];
          req.slot_id = 8'(pick);
          if (pool_phase[pick] == PH_READ) req.opcode = OP_READ_DONE;
          else if ($urandom_range(99) < 75) req.opcode = OP_WRITE_OK;
          else req.opcode = OP_WRITE_BAD;
        end
        pending_req_q = {pending_req_q, req};
      end
      wait_drained();
    end

    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      report_mismatch("responses never delivered", 0, expected_rsp_q.size());
    $display("Checked %0d responses over %0d threshold writes and %0d traffic phases",
             rsp_cnt, cfg_cnt, NUM_PHASES);
    $display("Write grants that reclaimed a prepared slot: %0d, acquires refused: %0d",
             overwrite_cnt, no_slot_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/fspm_pkg.sv
src/frame_slot_pool_manager.sv
tb/frame_slot_pool_manager_test.sv
